>>> rtl/rpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP packet fragmenter package
// Shared types and constants of the fragmenter front, queue and back.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int HeaderBytes = 12;
  localparam int HdrAw = $clog2(HeaderBytes);
  localparam int QueueDepth = 4;

  localparam logic [15:0] MaxDatagramReset = 16'd1400;
  localparam logic [HdrAw-1:0] HdrMarkerIdx = HdrAw'(1);
  localparam logic [HdrAw-1:0] HdrSeqHiIdx = HdrAw'(2);
  localparam logic [HdrAw-1:0] HdrSeqLoIdx = HdrAw'(3);
  localparam logic [HdrAw-1:0] HdrLastIdx = HdrAw'(HeaderBytes - 1);
  localparam logic [7:0] MarkerBit = 8'h80;
  localparam logic [7:0] MarkerClearMask = 8'h7f;

  typedef enum logic [1:0] {
    PATH_PASS = 2'd0,
    PATH_DROP = 2'd1,
    PATH_FRAG = 2'd2
  } path_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_REPLAY = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BACK_IDLE = 2'd0,
    BACK_HDR = 2'd1,
    BACK_BODY = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [15:0] packet_len;
    logic first_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic end_of_datagram;
    logic last_of_run;
  } out_beat_t;

  typedef struct packed {
    cmd_kind_e kind;
    logic [7:0] data;
    logic eod;
    logic marker;
    logic [15:0] seq;
  } cmd_t;

  typedef struct packed {
    logic we;
    logic [HdrAw-1:0] addr;
    logic [7:0] data;
  } hdr_wr_t;

  typedef struct packed {
    logic idle;
    logic queue_empty;
  } back_status_t;

endpackage

>>> rtl/rpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP fragmenter command queue
// Small register FIFO between the classifying front and the output back.
// ----------------------------------------------------------------------------
module rpf_queue #(
  parameter int QUEUE_DEPTH = rpf_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rpf_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rpf_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  rpf_pkg::cmd_t entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/rpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP fragmenter front
// Accepts packet bytes, tracks packet position and fragment fill, and turns
// each byte into a header write, a byte command or a header replay command, or drops it.
// ----------------------------------------------------------------------------
module rpf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rpf_pkg::in_beat_t     in_data_i,
  input  logic [15:0]           max_datagram_i,
  input  rpf_pkg::back_status_t back_status_i,
  output logic                  cmd_valid_o,
  output rpf_pkg::cmd_t         cmd_o,
  input  logic                  cmd_full_i,
  output rpf_pkg::hdr_wr_t      hdr_wr_o
);

  rpf_pkg::path_e path_q, path_d, path_n;
  logic [15:0] pos_q, pos_d;
  logic [15:0] fill_q, fill_d;
  logic [15:0] seq_q, seq_d;
  logic marker_q, marker_d;

  logic start, last_byte, hdr_pos, accept, final_frag, eod;
  logic [15:0] pos, fill, fill_inc, maxfrag, len, maxd;

  assign len = in_data_i.packet_len;
  assign maxd = max_datagram_i;

  always_comb begin
    start = in_data_i.first_byte || (pos_q == '0);
    if (len == '0) begin
      path_n = rpf_pkg::PATH_DROP;
    end else if (len <= maxd) begin
      path_n = rpf_pkg::PATH_PASS;
    end else if (maxd <= 16'(rpf_pkg::HeaderBytes) || len <= 16'(rpf_pkg::HeaderBytes)) begin
      path_n = rpf_pkg::PATH_DROP;
    end else begin
      path_n = rpf_pkg::PATH_FRAG;
    end
    path_d = start ? path_n : path_q;
    pos = start ? '0 : pos_q;
    fill = start ? '0 : fill_q;
    last_byte = ({1'b0, pos} + 17'd1) >= {1'b0, len};
    maxfrag = (maxd > 16'(rpf_pkg::HeaderBytes)) ? maxd - 16'(rpf_pkg::HeaderBytes) : 16'd1;
    hdr_pos = pos < 16'(rpf_pkg::HeaderBytes);
    final_frag = (len > pos) && ((len - pos) <= maxfrag);
    fill_inc = fill + 16'd1;
    eod = (fill_inc >= maxfrag) || last_byte;

    if (path_d == rpf_pkg::PATH_FRAG && hdr_pos) begin
      in_ready_o = back_status_i.idle && back_status_i.queue_empty;
    end else begin
      in_ready_o = !cmd_full_i;
    end
    accept = in_valid_i && in_ready_o;

    pos_d = pos_q;
    fill_d = fill_q;
    seq_d = seq_q;
    marker_d = marker_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind = rpf_pkg::CMD_BYTE;
    cmd_o.data = in_data_i.data_byte;
    cmd_o.eod = last_byte;
    cmd_o.marker = final_frag && marker_q;
    cmd_o.seq = seq_q;
    hdr_wr_o.we = 1'b0;
    hdr_wr_o.addr = pos[rpf_pkg::HdrAw-1:0];
    hdr_wr_o.data = in_data_i.data_byte;

    if (accept) begin
      fill_d = fill;
      case (path_d)
        rpf_pkg::PATH_PASS: begin
          cmd_valid_o = 1'b1;
        end
        rpf_pkg::PATH_FRAG: begin
          if (hdr_pos) begin
            hdr_wr_o.we = 1'b1;
            if (hdr_wr_o.addr == rpf_pkg::HdrMarkerIdx) begin
              marker_d = |(in_data_i.data_byte & rpf_pkg::MarkerBit);
            end else if (hdr_wr_o.addr == rpf_pkg::HdrSeqHiIdx) begin
              seq_d = {in_data_i.data_byte, seq_q[7:0]};
            end else if (hdr_wr_o.addr == rpf_pkg::HdrSeqLoIdx) begin
              seq_d = {seq_q[15:8], in_data_i.data_byte};
            end
          end else begin
            cmd_valid_o = 1'b1;
            cmd_o.kind = (fill == '0) ? rpf_pkg::CMD_REPLAY : rpf_pkg::CMD_BYTE;
            cmd_o.eod = eod;
            fill_d = fill_inc;
            if (eod) begin
              fill_d = '0;
              seq_d = seq_q + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
      if (last_byte) begin
        pos_d = '0;
        fill_d = '0;
      end else begin
        pos_d = pos + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q <= rpf_pkg::PATH_PASS;
      pos_q <= '0;
      fill_q <= '0;
      seq_q <= '0;
      marker_q <= 1'b0;
    end else begin
      if (accept) begin
        path_q <= path_d;
      end
      pos_q <= pos_d;
      fill_q <= fill_d;
      seq_q <= seq_d;
      marker_q <= marker_d;
    end
  end

endmodule

>>> rtl/rpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP fragmenter back
// Holds the header memory, replays the stored header ahead of each fragment
// and drives the registered output beat.
// ----------------------------------------------------------------------------
module rpf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpf_pkg::hdr_wr_t      hdr_wr_i,
  input  rpf_pkg::cmd_t         cmd_i,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  output rpf_pkg::back_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rpf_pkg::out_beat_t    out_data_o
);

  logic [7:0] hdr_mem [rpf_pkg::HeaderBytes];
  logic [7:0] rd_q;
  logic rd_en;
  logic [rpf_pkg::HdrAw-1:0] rd_addr;

  rpf_pkg::back_state_e state_q, state_d;
  logic [rpf_pkg::HdrAw-1:0] idx_q, idx_d;
  rpf_pkg::cmd_t cur_q, cur_d;
  logic out_valid_q, out_valid_d;
  rpf_pkg::out_beat_t out_q, out_d;
  logic slot_free;
  logic [7:0] hdr_byte;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign status_o.idle = (state_q == rpf_pkg::BACK_IDLE);
  assign status_o.queue_empty = cmd_empty_i;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    hdr_byte = rd_q;
    if (idx_q == rpf_pkg::HdrMarkerIdx) begin
      hdr_byte = (rd_q & rpf_pkg::MarkerClearMask) | (cur_q.marker ? rpf_pkg::MarkerBit : 8'h00);
    end else if (idx_q == rpf_pkg::HdrSeqHiIdx) begin
      hdr_byte = cur_q.seq[15:8];
    end else if (idx_q == rpf_pkg::HdrSeqLoIdx) begin
      hdr_byte = cur_q.seq[7:0];
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    cur_d = cur_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_pop_o = 1'b0;
    rd_en = 1'b0;
    rd_addr = idx_q + rpf_pkg::HdrAw'(1);
    case (state_q)
      rpf_pkg::BACK_IDLE: begin
        rd_addr = '0;
        if (!cmd_empty_i && slot_free) begin
          cmd_pop_o = 1'b1;
          cur_d = cmd_i;
          if (cmd_i.kind == rpf_pkg::CMD_REPLAY) begin
            rd_en = 1'b1;
            idx_d = '0;
            state_d = rpf_pkg::BACK_HDR;
          end else begin
            out_valid_d = 1'b1;
            out_d.out_byte = cmd_i.data;
            out_d.end_of_datagram = cmd_i.eod;
            out_d.last_of_run = 1'b1;
          end
        end
      end
      rpf_pkg::BACK_HDR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.out_byte = hdr_byte;
          out_d.end_of_datagram = 1'b0;
          out_d.last_of_run = 1'b0;
          if (idx_q == rpf_pkg::HdrLastIdx) begin
            state_d = rpf_pkg::BACK_BODY;
          end else begin
            rd_en = 1'b1;
            idx_d = idx_q + rpf_pkg::HdrAw'(1);
          end
        end
      end
      rpf_pkg::BACK_BODY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.out_byte = cur_q.data;
          out_d.end_of_datagram = cur_q.eod;
          out_d.last_of_run = 1'b1;
          state_d = rpf_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_d = rpf_pkg::BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpf_pkg::BACK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (hdr_wr_i.we) begin
      hdr_mem[hdr_wr_i.addr] <= hdr_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= hdr_mem[rd_addr];
    end
  end

endmodule

>>> rtl/rtp_packet_fragmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP packet fragmenter
// Takes RTP packet bytes and emits them as datagrams no larger than
// max_datagram, replaying the stored header ahead of each fragment.
// ----------------------------------------------------------------------------
// The block takes one packet byte per beat. Pass-through bytes and payload
// bytes that continue a fragment leave one beat per cycle while the output is
// not stalled. The first payload byte of each fragment leaves as 13 beats, header
// first, read by the replay sequencer from the 12-byte header memory one byte
// per cycle under the same condition. Header bytes of a fragmented packet are
// held at the input until the command queue and the replay sequencer have
// drained, since they overwrite the header memory; they produce no beats.
// max_datagram is written through the configuration channel and resets to 1400.
module rtp_packet_fragmenter_unit #(
  parameter int QUEUE_DEPTH = rpf_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpf_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpf_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] max_datagram_q;
  rpf_pkg::back_status_t back_status;
  rpf_pkg::hdr_wr_t hdr_wr;
  rpf_pkg::cmd_t push_cmd, pop_cmd;
  logic push_valid, queue_full, queue_empty, queue_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_datagram_q <= rpf_pkg::MaxDatagramReset;
    end else if (cfg_valid_i) begin
      max_datagram_q <= cfg_data_i;
    end
  end

  rpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .max_datagram_i (max_datagram_q),
    .back_status_i  (back_status),
    .cmd_valid_o    (push_valid),
    .cmd_o          (push_cmd),
    .cmd_full_i     (queue_full),
    .hdr_wr_o       (hdr_wr)
  );

  rpf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (queue_empty)
  );

  rpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_wr_i    (hdr_wr),
    .cmd_i       (pop_cmd),
    .cmd_empty_i (queue_empty),
    .cmd_pop_o   (queue_pop),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP packet fragmenter testbench
// Streams RTP packet bytes into the fragmenter and checks every outgoing
// datagram beat against an in-bench prediction of pass-through, drop and
// fragmentation with header replay, under random stalls on both sides and
// several max_datagram settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit = 1_000_000;
  localparam int SettleCycles = 40;
  localparam int RandomItems = 480;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  rpf_pkg::in_beat_t in_data = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_ready_o;
  logic out_valid_o;
  rpf_pkg::out_beat_t out_data_o;
  logic cfg_ready_o;

  // Predicted state of the fragmenter.
  logic [7:0] hdr_copy [rpf_pkg::HeaderBytes];
  logic [15:0] byte_pos = '0;
  logic [15:0] frag_fill = '0;
  logic [15:0] next_seq = '0;
  rpf_pkg::path_e pkt_path = rpf_pkg::PATH_PASS;
  logic marker = 1'b0;
  logic [15:0] max_dgram = rpf_pkg::MaxDatagramReset;

  rpf_pkg::out_beat_t datagram_q[$];
  int mismatch_count = 0;
  int item_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit in_held = 1'b0;

  rtp_packet_fragmenter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic rpf_pkg::out_beat_t make_beat(input logic [7:0] b, input logic eod);
    rpf_pkg::out_beat_t ob;
    ob.out_byte = b;
    ob.end_of_datagram = eod;
    ob.last_of_run = 1'b0;
    return ob;
  endfunction

  task automatic fragment_byte(input rpf_pkg::in_beat_t beat);
    rpf_pkg::out_beat_t run[$];
    logic [15:0] len;
    logic [15:0] pos;
    logic [15:0] frag_max;
    logic [7:0] hb;
    logic at_end;
    logic final_frag;
    logic close;
    len = beat.packet_len;
    if (beat.first_byte || byte_pos == 16'd0) begin
      byte_pos = '0;
      frag_fill = '0;
      if (len == 16'd0) begin
        pkt_path = rpf_pkg::PATH_DROP;
      end else if (len <= max_dgram) begin
        pkt_path = rpf_pkg::PATH_PASS;
      end else if (max_dgram <= rpf_pkg::HeaderBytes || len <= rpf_pkg::HeaderBytes) begin
        pkt_path = rpf_pkg::PATH_DROP;
      end else begin
        pkt_path = rpf_pkg::PATH_FRAG;
      end
    end
    pos = byte_pos;
    at_end = (17'(pos) + 17'd1 >= 17'(len));
    frag_max = (max_dgram > rpf_pkg::HeaderBytes) ?
               max_dgram - 16'(rpf_pkg::HeaderBytes) : 16'd1;
    case (pkt_path)
      rpf_pkg::PATH_PASS: begin
        run.push_back(make_beat(beat.data_byte, at_end));
      end
      rpf_pkg::PATH_FRAG: begin
        if (pos < rpf_pkg::HeaderBytes) begin
          hdr_copy[pos] = beat.data_byte;
          if (pos == rpf_pkg::HdrMarkerIdx) begin
            marker = (beat.data_byte & rpf_pkg::MarkerBit) != 8'h00;
          end else if (pos == rpf_pkg::HdrSeqHiIdx) begin
            next_seq[15:8] = beat.data_byte;
          end else if (pos == rpf_pkg::HdrSeqLoIdx) begin
            next_seq[7:0] = beat.data_byte;
          end
        end else begin
          if (frag_fill == 16'd0) begin
            final_frag = (len > pos) && (len - pos <= frag_max);
            for (int i = 0; i < rpf_pkg::HeaderBytes; i++) begin
              hb = hdr_copy[i];
              if (i == rpf_pkg::HdrMarkerIdx) begin
                hb = (hb & rpf_pkg::MarkerClearMask) |
                     ((final_frag && marker) ? rpf_pkg::MarkerBit : 8'h00);
              end else if (i == rpf_pkg::HdrSeqHiIdx) begin
                hb = next_seq[15:8];
              end else if (i == rpf_pkg::HdrSeqLoIdx) begin
                hb = next_seq[7:0];
              end
              run.push_back(make_beat(hb, 1'b0));
            end
          end
          frag_fill = frag_fill + 16'd1;
          close = (frag_fill >= frag_max) || at_end;
          run.push_back(make_beat(beat.data_byte, close));
          if (close) begin
            frag_fill = '0;
            next_seq = next_seq + 16'd1;
          end
        end
      end
      default: ;
    endcase
    if (at_end) begin
      byte_pos = '0;
      frag_fill = '0;
    end else begin
      byte_pos = pos + 16'd1;
    end
    item_count++;
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[k]) datagram_q.push_back(run[k]);
  endtask

  task automatic check_beat(input rpf_pkg::out_beat_t got);
    rpf_pkg::out_beat_t want;
    if (datagram_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: unexpected beat, got byte %02h eod %0b last %0b", $time,
                 got.out_byte, got.end_of_datagram, got.last_of_run);
      end
    end else begin
      want = datagram_q.pop_front();
      if (got.out_byte !== want.out_byte || got.end_of_datagram !== want.end_of_datagram ||
          got.last_of_run !== want.last_of_run) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: expected byte %02h eod %0b last %0b, got byte %02h eod %0b last %0b",
                   $time, want.out_byte, want.end_of_datagram, want.last_of_run,
                   got.out_byte, got.end_of_datagram, got.last_of_run);
        end
      end
    end
  endtask

  // Configuration, input and output beats are taken in this order at each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) max_dgram = cfg_data;
      if (in_valid && in_ready_o) fragment_byte(in_data);
      if (out_valid_o && out_ready) check_beat(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[rtp_packet_fragmenter_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic in_idle();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  task automatic send_beat(input logic [7:0] d, input logic [15:0] len, input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_idle();
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_held = 1'b1;
    in_data <= '{data_byte: d, packet_len: len, first_byte: first};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (datagram_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_datagram(input logic [15:0] value);
    in_idle();
    @(posedge clk_i);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_packet(input logic [15:0] plen, input int nbytes, input int cut_at,
                             input int stop_at);
    logic [15:0] len_now;
    logic first;
    for (int i = 0; i < nbytes && item_count < stop_at; i++) begin
      len_now = (i == cut_at) ? 16'(i + 1) : plen;
      first = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 199) == 0);
      send_beat(8'($urandom), len_now, first);
    end
  endtask

  task automatic test_pass_through();
    send_beat(8'h00, 16'd1, 1'b1);
    send_beat(8'hff, 16'd2, 1'b0);
    send_beat(8'h81, 16'd2, 1'b0);
  endtask

  task automatic test_zero_length();
    send_beat(8'h5a, 16'd0, 1'b0);
  endtask

  // The register drops to the header size in the middle of a fragmented
  // packet, and the packet is then cut short by a smaller length.
  task automatic test_fragment_live_change();
    logic [7:0] hdr [rpf_pkg::HeaderBytes];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = 8'h80;
    hdr[1] = 8'he0;
    hdr[2] = 8'hff;
    hdr[3] = 8'hff;
    write_max_datagram(16'd14);
    for (int i = 0; i < rpf_pkg::HeaderBytes; i++) send_beat(hdr[i], 16'd16, i == 0);
    send_beat(8'h00, 16'd16, 1'b0);
    write_max_datagram(16'd12);
    send_beat(8'hff, 16'd16, 1'b0);
    send_beat(8'h3c, 16'd15, 1'b0);
  endtask

  task automatic test_oversize_drop();
    send_beat(8'ha5, 16'd40, 1'b1);
    send_beat(8'h12, 16'd12, 1'b1);
  endtask

  task automatic test_wide_packet();
    write_max_datagram(16'hffff);
    send_beat(8'hff, 16'hffff, 1'b1);
    send_beat(8'h00, 16'd1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    int plen;
    int nb;
    int cut;
    logic [15:0] m;
    target = item_count + RandomItems;
    while (item_count < target) begin
      r = $urandom_range(0, 19);
      if (r == 0) m = 16'd0;
      else if (r == 1) m = 16'd12;
      else if (r == 2) m = 16'hffff;
      else if (r < 6) m = rpf_pkg::MaxDatagramReset;
      else if (r == 6) m = 16'($urandom);
      else m = 16'($urandom_range(13, 60));
      write_max_datagram(m);
      quiet = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 6)) begin
        if (item_count >= target) break;
        if (m <= 16'd12) begin
          plen = $urandom_range(1, 40);
        end else if (m > 16'd200) begin
          r = $urandom_range(0, 9);
          if (r < 7) plen = $urandom_range(1, 60);
          else if (r < 9 || m >= 16'd65500) plen = $urandom_range(1, 65535);
          else plen = int'(m) + $urandom_range(1, 20);
        end else begin
          plen = $urandom_range(1, 3 * int'(m));
        end
        nb = plen;
        if (nb > 60 || $urandom_range(0, 7) == 0) begin
          nb = $urandom_range(1, (plen < 60) ? plen : 60);
        end
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nb - 1) : -1;
        send_packet(16'(plen), nb, cut, target);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pass_through();
    test_zero_length();
    test_fragment_live_change();
    test_oversize_drop();
    test_wide_packet();
    test_random_traffic();
    in_idle();
    @(posedge clk_i);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && datagram_q.size() == 0) begin
      $display("[rtp_packet_fragmenter_unit] OK");
    end else begin
      $display("[rtp_packet_fragmenter_unit] ERROR");
    end
    $finish;
  end

endmodule
